// ===== hw/rtl/pts_pkg.sv =====
// shared types and constants of the three-level preemptive task scheduler
package pts_pkg;

	localparam int NUM_LEVELS = 3;
	localparam int LVL_W = 2;
	localparam int TAG_W = 16;
	localparam int DUR_W = 8;
	localparam int PRIO_W = 2;

	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int STACK_DEPTH_DEF = 8;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [DUR_W-1:0] dur;
	} fifo_entry_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [DUR_W-1:0]  dur;
		logic [PRIO_W-1:0] prio;
	} task_t;

	typedef struct packed {
		logic                  accepted;
		logic [NUM_LEVELS-1:0] nonempty;
	} fifo_status_t;

endpackage

// ===== hw/rtl/preemptive_priority_task_scheduler_top.sv =====
// Three-level preemptive priority task scheduler.
// Each input word is one scheduler tick and may carry an arriving task
// (arrival_valid) with its level 0..2, service time and tag. The task joins
// its level's ring fifo or is refused when that fifo is full (or level 3);
// the source then presents it again on a later tick.
// Per tick: the preemption stack top resumes if the processor is idle or
// runs a worse level, the best non-empty level dispatches or preempts (level
// 2 never preempts), the running task is served one tick and retires at zero.
// Each tick yields exactly one output word.
// A word taken into the input register has its result registered in the result
// register once that register is empty or its word is taken (out_stall low).
// Throughput: one tick per cycle while out_stall does not hold the result; the
// whole decision is combinational because the next tick needs the state this one leaves.
// Reset empties the fifos and the stack and leaves the processor idle.
// When out_stall is high the result is held; an empty input register still
// takes one more word, after which in_stall stays high until the result drains.
module preemptive_priority_task_scheduler_top #(
	parameter int QUEUE_DEPTH = pts_pkg::QUEUE_DEPTH_DEF,
	parameter int STACK_DEPTH = pts_pkg::STACK_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       arrival_valid,
	input  logic [pts_pkg::PRIO_W-1:0] arrival_priority,
	input  logic [pts_pkg::DUR_W-1:0]  arrival_duration,
	input  logic [pts_pkg::TAG_W-1:0]  arrival_tag,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       arrival_accepted,
	output logic                       running_valid,
	output logic [pts_pkg::TAG_W-1:0]  running_tag,
	output logic [pts_pkg::PRIO_W-1:0] running_priority,
	output logic [pts_pkg::DUR_W-1:0]  remaining_ticks,
	output logic                       task_finished,
	output logic                       all_idle,
	output logic                       stack_overflow
);

	localparam int LW  = $clog2(STACK_DEPTH + 1);
	localparam int SIW = $clog2(STACK_DEPTH);

	// input register
	logic                       valid_s1;
	logic                       arr_valid_s1;
	logic [pts_pkg::PRIO_W-1:0] arr_prio_s1;
	pts_pkg::fifo_entry_t       arr_entry_s1;

	// scheduler state
	pts_pkg::task_t stack_q [STACK_DEPTH];
	logic [LW-1:0]  lvl_q;
	pts_pkg::task_t cur_q;
	logic           cur_v_q;

	// result register
	logic                       out_valid_q;
	logic                       accepted_q;
	logic                       run_v_q;
	logic [pts_pkg::TAG_W-1:0]  run_tag_q;
	logic [pts_pkg::PRIO_W-1:0] run_prio_q;
	logic [pts_pkg::DUR_W-1:0]  rem_q;
	logic                       fin_q;
	logic                       idle_q;
	logic                       ovf_q;

	logic in_accept;
	logic step;

	pts_pkg::fifo_status_t                          fstat;
	pts_pkg::fifo_entry_t [pts_pkg::NUM_LEVELS-1:0] heads;

	logic [LW-1:0]              lvl_dec;
	pts_pkg::task_t             top;
	logic                       resume;
	logic                       wa;
	pts_pkg::task_t             cur1;
	logic                       v1;
	logic [LW-1:0]              lvl1;
	logic                       found;
	logic [pts_pkg::LVL_W-1:0]  best;
	pts_pkg::task_t             disp;
	logic                       pop;
	logic                       wb;
	logic                       ovf;
	pts_pkg::task_t             cur2;
	logic                       v2;
	logic [LW-1:0]              lvl2;
	logic [pts_pkg::DUR_W-1:0]  rem;
	logic                       fin;
	pts_pkg::task_t             cur_n;
	logic                       idle;

	assign step      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !step;
	assign in_accept = in_valid && !in_stall;

	pts_level_fifos #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_fifos (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.arr_valid(arr_valid_s1),
		.arr_prio (arr_prio_s1),
		.arr_entry(arr_entry_s1),
		.pop      (pop),
		.pop_level(best),
		.status   (fstat),
		.heads    (heads)
	);

	always_comb begin
		lvl_dec = lvl_q - LW'(1);
		top = stack_q[lvl_dec[SIW-1:0]];

		// stack resume; a displaced running task takes the popped slot
		cur1   = cur_q;
		v1     = cur_v_q;
		lvl1   = lvl_q;
		wa     = 1'b0;
		resume = (lvl_q != '0) && (!cur_v_q || (cur_q.prio > top.prio));
		if (resume) begin
			cur1 = top;
			v1   = 1'b1;
			if (cur_v_q)
				wa = 1'b1;
			else
				lvl1 = lvl_dec;
		end

		// best non-empty level
		found = 1'b1;
		if (fstat.nonempty[0])
			best = pts_pkg::LVL_W'(0);
		else if (fstat.nonempty[1])
			best = pts_pkg::LVL_W'(1);
		else if (fstat.nonempty[2])
			best = pts_pkg::LVL_W'(2);
		else begin
			best  = pts_pkg::LVL_W'(0);
			found = 1'b0;
		end
		disp.tag  = heads[best].tag;
		disp.dur  = heads[best].dur;
		disp.prio = best;

		cur2 = cur1;
		v2   = v1;
		lvl2 = lvl1;
		pop  = 1'b0;
		wb   = 1'b0;
		ovf  = 1'b0;
		if (found) begin
			if (!v1) begin
				cur2 = disp;
				v2   = 1'b1;
				pop  = 1'b1;
			end else if (cur1.prio > best) begin
				if (lvl1 < LW'(STACK_DEPTH)) begin
					wb   = 1'b1;
					lvl2 = lvl1 + LW'(1);
					cur2 = disp;
					pop  = 1'b1;
				end else begin
					ovf = 1'b1;
				end
			end
		end

		// serve one tick, saturating at zero
		rem = (cur2.dur != '0) ? cur2.dur - pts_pkg::DUR_W'(1) : '0;
		fin = v2 && (rem == '0);
		cur_n = cur2;
		cur_n.dur = rem;
		idle = !v2 && (fstat.nonempty == '0) && (lvl2 == '0);
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			arr_valid_s1     <= arrival_valid;
			arr_prio_s1      <= arrival_priority;
			arr_entry_s1.tag <= arrival_tag;
			arr_entry_s1.dur <= arrival_duration;
		end
		if (step) begin
			for (int i = 0; i < STACK_DEPTH; i++) begin
				if (wa && (lvl_dec[SIW-1:0] == SIW'(i)))
					stack_q[i] <= cur_q;
				else if (wb && (lvl1[SIW-1:0] == SIW'(i)))
					stack_q[i] <= cur1;
			end
			accepted_q <= fstat.accepted;
			run_v_q    <= v2;
			run_tag_q  <= v2 ? cur2.tag : '0;
			run_prio_q <= v2 ? cur2.prio : '0;
			rem_q      <= v2 ? rem : '0;
			fin_q      <= fin;
			idle_q     <= idle;
			ovf_q      <= ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			lvl_q       <= '0;
			cur_q       <= '0;
			cur_v_q     <= 1'b0;
		end else begin
			valid_s1    <= in_accept || (valid_s1 && !step);
			out_valid_q <= step || (out_valid_q && out_stall);
			if (step) begin
				lvl_q   <= lvl2;
				cur_q   <= cur_n;
				cur_v_q <= v2 && !fin;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign arrival_accepted = accepted_q;
	assign running_valid    = run_v_q;
	assign running_tag      = run_tag_q;
	assign running_priority = run_prio_q;
	assign remaining_ticks  = rem_q;
	assign task_finished    = fin_q;
	assign all_idle         = idle_q;
	assign stack_overflow   = ovf_q;

endmodule

// ===== hw/rtl/pts_level_fifos.sv =====
// per-level ring fifos with arrival write, head bypass and dispatch pop
module pts_level_fifos #(
	parameter int QUEUE_DEPTH = pts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        step,
	input  logic                                        arr_valid,
	input  logic [pts_pkg::PRIO_W-1:0]                  arr_prio,
	input  pts_pkg::fifo_entry_t                        arr_entry,
	input  logic                                        pop,
	input  logic [pts_pkg::LVL_W-1:0]                   pop_level,
	output pts_pkg::fifo_status_t                       status,
	output pts_pkg::fifo_entry_t [pts_pkg::NUM_LEVELS-1:0] heads
);

	localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;

	pts_pkg::fifo_entry_t mem_q [pts_pkg::NUM_LEVELS][QUEUE_DEPTH];
	logic [HW-1:0] head_q [pts_pkg::NUM_LEVELS];
	logic [CW-1:0] cnt_q  [pts_pkg::NUM_LEVELS];

	logic [pts_pkg::NUM_LEVELS-1:0] hit;
	logic [pts_pkg::NUM_LEVELS-1:0] pop_lv;
	logic [HW-1:0] wr_slot [pts_pkg::NUM_LEVELS];
	logic [CW-1:0] cnt_a   [pts_pkg::NUM_LEVELS];
	logic [SW-1:0] slot_sum [pts_pkg::NUM_LEVELS];

	always_comb begin
		for (int lv = 0; lv < pts_pkg::NUM_LEVELS; lv++) begin
			hit[lv] = arr_valid && (arr_prio == pts_pkg::PRIO_W'(lv))
				&& (cnt_q[lv] < CW'(QUEUE_DEPTH));
			// head plus fill stays below twice the depth
			slot_sum[lv] = SW'(head_q[lv]) + SW'(cnt_q[lv]);
			if (slot_sum[lv] >= SW'(QUEUE_DEPTH))
				wr_slot[lv] = HW'(slot_sum[lv] - SW'(QUEUE_DEPTH));
			else
				wr_slot[lv] = HW'(slot_sum[lv]);
			cnt_a[lv] = cnt_q[lv] + CW'(hit[lv]);
			status.nonempty[lv] = (cnt_a[lv] != '0);
			// an empty level hands the arriving word straight to dispatch
			if (cnt_q[lv] == '0)
				heads[lv] = arr_entry;
			else
				heads[lv] = mem_q[lv][head_q[lv]];
			pop_lv[lv] = pop && (pop_level == pts_pkg::LVL_W'(lv));
		end
		status.accepted = |hit;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int lv = 0; lv < pts_pkg::NUM_LEVELS; lv++) begin
				if (hit[lv])
					mem_q[lv][wr_slot[lv]] <= arr_entry;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int lv = 0; lv < pts_pkg::NUM_LEVELS; lv++) begin
				head_q[lv] <= '0;
				cnt_q[lv]  <= '0;
			end
		end else if (step) begin
			for (int lv = 0; lv < pts_pkg::NUM_LEVELS; lv++) begin
				if (pop_lv[lv]) begin
					if (head_q[lv] == HW'(QUEUE_DEPTH - 1))
						head_q[lv] <= '0;
					else
						head_q[lv] <= head_q[lv] + HW'(1);
					cnt_q[lv] <= cnt_a[lv] - CW'(1);
				end else begin
					cnt_q[lv] <= cnt_a[lv];
				end
			end
		end
	end

endmodule

// ===== tb/tb_preemptive_priority_task_scheduler_top.sv =====
// testbench for the three-level preemptive priority task scheduler top level
module tb_preemptive_priority_task_scheduler_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pts_pkg::*;

	localparam int QDEPTH = QUEUE_DEPTH_DEF;
	localparam int SDEPTH = STACK_DEPTH_DEF;
	localparam int RANDOM_TICKS = 1150;

	typedef struct packed {
		logic              accepted;
		logic              run_valid;
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
		logic [DUR_W-1:0]  remaining;
		logic              finished;
		logic              idle;
		logic              overflow;
	} tick_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              arrival_valid = 1'b0;
	logic [PRIO_W-1:0] arrival_priority = '0;
	logic [DUR_W-1:0]  arrival_duration = '0;
	logic [TAG_W-1:0]  arrival_tag = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              arrival_accepted;
	logic              running_valid;
	logic [TAG_W-1:0]  running_tag;
	logic [PRIO_W-1:0] running_priority;
	logic [DUR_W-1:0]  remaining_ticks;
	logic              task_finished;
	logic              all_idle;
	logic              stack_overflow;

	preemptive_priority_task_scheduler_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.arrival_valid    (arrival_valid),
		.arrival_priority (arrival_priority),
		.arrival_duration (arrival_duration),
		.arrival_tag      (arrival_tag),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.arrival_accepted (arrival_accepted),
		.running_valid    (running_valid),
		.running_tag      (running_tag),
		.running_priority (running_priority),
		.remaining_ticks  (remaining_ticks),
		.task_finished    (task_finished),
		.all_idle         (all_idle),
		.stack_overflow   (stack_overflow)
	);

	always #10 clk = ~clk;

	// scheduler state as predicted
	task_t       level_slots [NUM_LEVELS][QDEPTH];
	int unsigned level_head [NUM_LEVELS] = '{default: 0};
	int unsigned level_fill [NUM_LEVELS] = '{default: 0};
	task_t       held_stack [SDEPTH];
	int unsigned held_depth = 0;
	task_t       running = '0;
	logic        running_on = 1'b0;

	tick_word_t expected_words [$];
	int         mismatches = 0;

	// sender idling
	logic gaps_on = 1'b1;
	int   burst_left = 0;

	// receiver stall pattern
	int unsigned rx_cycle = 0;
	int unsigned rx_run = 0;
	logic        rx_hold = 1'b0;

	function automatic task_t pop_level(input int lv);
		task_t t;
		t = level_slots[lv][level_head[lv]];
		level_head[lv] = (level_head[lv] + 1) % QDEPTH;
		level_fill[lv]--;
		return t;
	endfunction

	function automatic tick_word_t schedule_tick(input logic av, input logic [PRIO_W-1:0] ap,
			input logic [DUR_W-1:0] ad, input logic [TAG_W-1:0] at);
		tick_word_t w;
		task_t top;
		int best;
		int slot;
		w = '0;
		best = -1;
		if (av && ap < NUM_LEVELS && level_fill[ap] < QDEPTH) begin
			slot = (level_head[ap] + level_fill[ap]) % QDEPTH;
			level_slots[ap][slot] = '{tag: at, dur: ad, prio: ap};
			level_fill[ap]++;
			w.accepted = 1'b1;
		end
		// stack top resumes into an idle or worse-level processor
		if (held_depth > 0) begin
			top = held_stack[held_depth-1];
			if (!running_on || running.prio > top.prio) begin
				held_depth--;
				if (running_on) begin
					held_stack[held_depth] = running;
					held_depth++;
				end
				running = top;
				running_on = 1'b1;
			end
		end
		for (int lv = 0; lv < NUM_LEVELS; lv++)
			if (best < 0 && level_fill[lv] != 0)
				best = lv;
		if (best >= 0) begin
			if (!running_on) begin
				running = pop_level(best);
				running_on = 1'b1;
			end else if (running.prio > best) begin
				if (held_depth < SDEPTH) begin
					held_stack[held_depth] = running;
					held_depth++;
					running = pop_level(best);
				end else begin
					w.overflow = 1'b1;
				end
			end
		end
		if (running_on) begin
			running.dur = (running.dur != 0) ? running.dur - 1'b1 : '0;
			w.run_valid = 1'b1;
			w.tag = running.tag;
			w.prio = running.prio;
			w.remaining = running.dur;
			if (running.dur == 0) begin
				w.finished = 1'b1;
				running_on = 1'b0;
			end
		end else begin
			w.idle = (level_fill[0] == 0 && level_fill[1] == 0 && level_fill[2] == 0 &&
				held_depth == 0);
		end
		return w;
	endfunction

	task automatic record_failure(input string msg);
		if (mismatches < 10)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// present one tick word, wait for it to be taken, then maybe pause
	task automatic send_tick(input logic av, input logic [PRIO_W-1:0] ap,
			input logic [DUR_W-1:0] ad, input logic [TAG_W-1:0] at, output logic acc);
		tick_word_t w;
		int gap;
		in_valid <= 1'b1;
		arrival_valid <= av;
		arrival_priority <= ap;
		arrival_duration <= ad;
		arrival_tag <= at;
		do @(posedge clk); while (in_stall);
		w = schedule_tick(av, ap, ad, at);
		expected_words.push_back(w);
		acc = w.accepted;
		if (gaps_on) begin
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 24);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	always @(posedge clk) begin
		rx_cycle++;
		case ((rx_cycle / 97) % 4)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: begin
				// long stall runs alternating with free runs
				if (rx_run == 0) begin
					rx_hold = ~rx_hold;
					rx_run = rx_hold ? $urandom_range(3, 15) : $urandom_range(1, 10);
				end
				rx_run--;
				out_stall <= rx_hold;
			end
			default: out_stall <= rx_cycle[0];
		endcase
	end

	always @(posedge clk) begin
		tick_word_t got;
		tick_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{arrival_accepted, running_valid, running_tag, running_priority,
				remaining_ticks, task_finished, all_idle, stack_overflow};
			if (expected_words.size() == 0) begin
				record_failure($sformatf("unexpected word %p", got));
			end else begin
				want = expected_words.pop_front();
				if (got !== want)
					record_failure($sformatf("expected %p got %p", want, got));
			end
		end
	end

	task automatic test_idle_ticks();
		logic acc;
		send_tick(1'b0, 2'b11, 8'hff, 16'hffff, acc);
		send_tick(1'b0, 2'b00, 8'h00, 16'h0000, acc);
	endtask

	// level 2 runs, level 1 preempts it, level 0 preempts level 1, then both resume
	task automatic test_preemption_chain();
		logic acc;
		send_tick(1'b1, 2'd2, 8'd3, 16'h0010, acc);
		send_tick(1'b1, 2'd1, 8'd2, 16'h0011, acc);
		send_tick(1'b1, 2'd0, 8'd1, 16'h0012, acc);
		repeat (4) send_tick(1'b0, 2'd0, 8'd0, 16'h0000, acc);
	endtask

	// a full level fifo refuses; the word is held and offered again
	task automatic test_fifo_full_refusal();
		logic acc;
		send_tick(1'b1, 2'd0, 8'd4, 16'h0020, acc);
		send_tick(1'b1, 2'd0, 8'd2, 16'h0021, acc);
		send_tick(1'b1, 2'd0, 8'd2, 16'h0022, acc);
		do send_tick(1'b1, 2'd0, 8'd1, 16'h0023, acc); while (!acc);
	endtask

	task automatic test_invalid_level();
		logic acc;
		send_tick(1'b1, 2'd3, 8'hff, 16'hffff, acc);
	endtask

	// zero service retires at once; the longest service is left to be preempted
	task automatic test_duration_extremes();
		logic acc;
		send_tick(1'b1, 2'd1, 8'd0, 16'h0000, acc);
		send_tick(1'b1, 2'd2, 8'd255, 16'hffff, acc);
		send_tick(1'b1, 2'd0, 8'd1, 16'h8000, acc);
		send_tick(1'b1, 2'd1, 8'd1, 16'h7fff, acc);
	endtask

	task automatic test_random_traffic();
		logic acc;
		logic held;
		logic av;
		logic [PRIO_W-1:0] ap;
		logic [DUR_W-1:0] ad;
		logic [TAG_W-1:0] at;
		logic [TAG_W-1:0] next_tag;
		int sel;
		held = 1'b0;
		next_tag = 16'h0100;
		for (int i = 0; i < RANDOM_TICKS; i++) begin
			gaps_on = !(i >= 450 && i < 650);
			// a refused task is mostly offered again unchanged
			if (!(held && $urandom_range(0, 7) != 0)) begin
				av = ($urandom_range(0, 9) < 6);
				ap = ($urandom_range(0, 15) == 0) ? 2'd3 : PRIO_W'($urandom_range(0, 2));
				sel = $urandom_range(0, 31);
				if (sel == 0)
					ad = 8'd0;
				else if (sel == 1)
					ad = 8'd255;
				else if (sel < 6)
					ad = DUR_W'($urandom_range(0, 255));
				else
					ad = DUR_W'($urandom_range(1, 8));
				if ($urandom_range(0, 7) == 0) begin
					at = TAG_W'($urandom);
				end else begin
					at = next_tag;
					next_tag++;
				end
			end
			send_tick(av, ap, ad, at, acc);
			held = av && ap < NUM_LEVELS && !acc;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_preemption_chain();
		test_fifo_full_refusal();
		test_invalid_level();
		test_duration_extremes();
		test_random_traffic();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (expected_words.size() != 0)
			record_failure("words still expected at end of run");
		if (mismatches == 0) begin
			$display("** preemptive_priority_task_scheduler_top: PASSED **");
		end else begin
			$display("** preemptive_priority_task_scheduler_top: FAILED **");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("** preemptive_priority_task_scheduler_top: FAILED **");
		$finish;
	end

endmodule
